FILE: rtl/core/erl_pkg.sv
`timescale 1ns / 1ps

package erl_pkg;

  // default ring depth
  localparam int LogDepthDefault = 256;

  localparam int CapW   = 9;
  localparam int CountW = 9;
  localparam int IndexW = 8;
  localparam int DropW  = 64;

  localparam logic [CapW-1:0] CapReset = 9'd256;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } erl_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        frame_number;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] cell_z;
    logic [31:0]        cell_level;
    logic [7:0]         world_layer;
    logic [1:0]         event_kind;
    logic [IndexW-1:0]  read_index;
  } erl_req_t;

  typedef struct packed {
    logic               entry_valid;
    logic [63:0]        out_frame;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_level;
    logic [7:0]         out_layer;
    logic [1:0]         out_kind;
    logic [CountW-1:0]  stored_count;
    logic [DropW-1:0]   dropped_count;
    logic               log_wrapped;
  } erl_res_t;

  // one stored event
  typedef struct packed {
    logic [63:0]        frame;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        level;
    logic [7:0]         layer;
    logic [1:0]         kind;
  } erl_entry_t;

  localparam int EntryW = $bits(erl_entry_t);

  // status of one operation, aligned with the ram read data
  typedef struct packed {
    logic              valid;
    logic              entry_valid;
    logic [CountW-1:0] stored_count;
    logic [DropW-1:0]  dropped_count;
    logic              log_wrapped;
  } erl_stat_t;

endpackage

FILE: rtl/core/erl_ram.sv
`timescale 1ns / 1ps

module erl_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/erl_ctrl.sv
`timescale 1ns / 1ps

module erl_ctrl #(
  parameter int LogDepth = erl_pkg::LogDepthDefault,
  localparam int AddrW = (LogDepth > 1) ? $clog2(LogDepth) : 1,
  localparam int CntW  = $clog2(LogDepth + 1),
  localparam int WorkW = (CntW > erl_pkg::CapW) ? CntW : erl_pkg::CapW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  erl_pkg::erl_req_t            req_i,
  input  logic                         cfg_we_i,
  input  logic [erl_pkg::CapW-1:0]     cfg_data_i,
  output logic                         ram_we_o,
  output logic [AddrW-1:0]             ram_waddr_o,
  output erl_pkg::erl_entry_t          ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AddrW-1:0]             ram_raddr_o,
  output erl_pkg::erl_stat_t           stat_o
);

  logic [CntW-1:0]              fill_q, fill_d;
  logic [AddrW-1:0]             oldest_q, oldest_d;
  logic                         wrapped_q, wrapped_d;
  logic [erl_pkg::DropW-1:0]    drop_q, drop_d;
  logic [erl_pkg::CapW-1:0]     cap_q;
  erl_pkg::erl_stat_t           stat_q, stat_d;

  logic [WorkW-1:0] cap_raw, cap_eff, fill_ext, oldest_ext, idx_ext;
  logic [WorkW:0]   rd_sum, rd_pos;
  logic             is_record, is_read, is_clear, has_room, rd_hit;

  always_comb begin
    cap_raw = WorkW'(cap_q);
    if (cap_raw == '0) begin
      cap_eff = WorkW'(1);
    end else if (cap_raw > WorkW'(LogDepth)) begin
      cap_eff = WorkW'(LogDepth);
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign fill_ext   = WorkW'(fill_q);
  assign oldest_ext = WorkW'(oldest_q);
  assign idx_ext    = WorkW'(req_i.read_index);
  assign has_room   = fill_ext < cap_eff;
  assign rd_hit     = idx_ext < fill_ext;

  // oldest stays below the fill count, so one subtract brings the sum in range
  assign rd_sum = {1'b0, oldest_ext} + {1'b0, idx_ext};
  assign rd_pos = (rd_sum >= {1'b0, fill_ext}) ? rd_sum - {1'b0, fill_ext} : rd_sum;

  assign is_record = fire_i && (req_i.operation == erl_pkg::OP_RECORD);
  assign is_read   = fire_i && (req_i.operation == erl_pkg::OP_READ);
  assign is_clear  = fire_i && (req_i.operation == erl_pkg::OP_CLEAR);

  always_comb begin
    fill_d    = fill_q;
    oldest_d  = oldest_q;
    wrapped_d = wrapped_q;
    drop_d    = drop_q;
    ram_we_o  = 1'b0;
    ram_waddr_o = oldest_q;
    if (cfg_we_i || is_clear) begin
      fill_d    = '0;
      oldest_d  = '0;
      wrapped_d = 1'b0;
      drop_d    = '0;
    end else if (is_record) begin
      ram_we_o = 1'b1;
      if (has_room) begin
        ram_waddr_o = AddrW'(fill_q);
        fill_d      = fill_q + CntW'(1);
      end else begin
        ram_waddr_o = oldest_q;
        oldest_d    = ((oldest_ext + WorkW'(1)) == cap_eff) ? '0 : oldest_q + AddrW'(1);
        wrapped_d   = 1'b1;
        drop_d      = drop_q + erl_pkg::DropW'(1);
      end
    end
  end

  assign ram_wdata_o = '{
    frame: req_i.frame_number,
    x:     req_i.cell_x,
    y:     req_i.cell_y,
    z:     req_i.cell_z,
    level: req_i.cell_level,
    layer: req_i.world_layer,
    kind:  req_i.event_kind
  };

  assign ram_re_o    = is_read && rd_hit;
  assign ram_raddr_o = AddrW'(rd_pos);

  always_comb begin
    stat_d.valid         = fire_i;
    stat_d.entry_valid   = is_read && rd_hit;
    stat_d.stored_count  = erl_pkg::CountW'(fill_d);
    stat_d.dropped_count = drop_d;
    stat_d.log_wrapped   = wrapped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      oldest_q  <= '0;
      wrapped_q <= 1'b0;
      drop_q    <= '0;
      cap_q     <= erl_pkg::CapReset;
      stat_q    <= '0;
    end else begin
      fill_q    <= fill_d;
      oldest_q  <= oldest_d;
      wrapped_q <= wrapped_d;
      drop_q    <= drop_d;
      stat_q    <= stat_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  assign stat_o = stat_q;

endmodule

FILE: rtl/core/overwriting_event_ring_log_top.sv
`timescale 1ns / 1ps

// Overwrite-oldest event trace ring. A command is taken on every clock edge
// where start is high and busy is low; busy is only high while the block
// comes out of reset, so one command per cycle is sustained. Every command
// (record, read, clear, and the spare code which does nothing) gives exactly
// one result, shown for a single cycle with res_valid_o high, once the command
// has passed the registered read of the entry ram and then the result
// register. The receiver cannot stall the block, so results must be taken
// as they come. A write of the capacity register also empties the log; it
// must only be made while no command is in flight.

module overwriting_event_ring_log_top #(
  parameter int LogDepth = erl_pkg::LogDepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  erl_pkg::erl_req_t        req_i,
  // result channel
  output logic                     res_valid_o,
  output erl_pkg::erl_res_t        res_o,
  // capacity register write
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [erl_pkg::CapW-1:0] cfg_data_i
);

  localparam int AddrW = (LogDepth > 1) ? $clog2(LogDepth) : 1;

  logic                busy_q;
  logic                fire;
  logic                cfg_we;
  logic                ram_we, ram_re;
  logic [AddrW-1:0]    ram_waddr, ram_raddr;
  erl_pkg::erl_entry_t ram_wdata, ram_rdata;
  erl_pkg::erl_stat_t  stat;
  logic                res_valid_q;
  erl_pkg::erl_res_t   res_q, res_d;

  // busy is set by reset and cleared by the first clock after it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign fire        = start & ~busy_q;
  assign cfg_we      = cfg_valid_i & ~busy_q;

  // ring state, entry addressing and per-command status
  erl_ctrl #(
    .LogDepth (LogDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .stat_o      (stat)
  );

  // entry store, all event fields side by side in one word
  erl_ram #(
    .Width (erl_pkg::EntryW),
    .Depth (LogDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entry fields read as zero unless a read hit a stored entry
  always_comb begin
    res_d.entry_valid   = stat.entry_valid;
    res_d.out_frame     = stat.entry_valid ? ram_rdata.frame : '0;
    res_d.out_x         = stat.entry_valid ? ram_rdata.x     : '0;
    res_d.out_y         = stat.entry_valid ? ram_rdata.y     : '0;
    res_d.out_z         = stat.entry_valid ? ram_rdata.z     : '0;
    res_d.out_level     = stat.entry_valid ? ram_rdata.level : '0;
    res_d.out_layer     = stat.entry_valid ? ram_rdata.layer : '0;
    res_d.out_kind      = stat.entry_valid ? ram_rdata.kind  : '0;
    res_d.stored_count  = stat.stored_count;
    res_d.dropped_count = stat.dropped_count;
    res_d.log_wrapped   = stat.log_wrapped;
  end

  // result register, strobe is control state and the payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= stat.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.valid) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: tb/overwriting_event_ring_log_top_tb.sv
`timescale 1ns / 1ps

module overwriting_event_ring_log_top_tb;
  import erl_pkg::*;

  // spare command code, not part of the enum: no state change
  localparam logic [1:0] OpSpare = 2'd3;
  localparam int RingDepth = LogDepthDefault;
  // settling margin that drain waits out once no result is pending
  localparam int ResLatency = 2;
  localparam int DrainLimit = 2000;

  // one line of the directed stimulus: either a capacity write or a command
  typedef struct {
    bit               is_cfg;
    logic [CapW-1:0]  cap;
    erl_req_t         req;
    bit               typed;
    erl_res_t         res;
  } stim_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  erl_req_t        req_i;
  logic            res_valid_o;
  erl_res_t        res_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CapW-1:0] cfg_data_i;

  // typed-in expectation travels alongside the command it belongs to
  logic            drv_typed;
  erl_res_t        drv_typed_res;

  // mirror of the log state
  erl_entry_t      ring_mirror [RingDepth];
  int unsigned     mirror_fill;
  int unsigned     mirror_oldest;
  logic            mirror_wrapped;
  logic [63:0]     mirror_dropped;
  logic [CapW-1:0] mirror_cap;

  erl_res_t        pending_res_q [$];
  stim_row_t       directed_q [$];

  int              error_count;
  int              n_records, n_reads, n_hits, n_clears, n_spare;
  int              n_overwrites, n_cap_writes, n_results;

  overwriting_event_ring_log_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("[overwriting_event_ring_log_top] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // mirror of the log
  // ---------------------------------------------------------------------

  // 0 behaves as 1, anything above the ring depth behaves as the depth
  function automatic int unsigned effective_cap(logic [CapW-1:0] v);
    if (v == '0) return 1;
    if (v > RingDepth) return RingDepth;
    return v;
  endfunction

  function automatic void empty_mirror();
    mirror_fill    = 0;
    mirror_oldest  = 0;
    mirror_wrapped = 1'b0;
    mirror_dropped = '0;
  endfunction

  // capacity write also empties the log
  function automatic void mirror_set_capacity(logic [CapW-1:0] v);
    mirror_cap = v;
    empty_mirror();
    n_cap_writes++;
  endfunction

  // advance the mirror by one command and return the result it gives
  function automatic erl_res_t ring_log_step(erl_req_t rq);
    erl_res_t    r;
    erl_entry_t  ev;
    int unsigned cap;
    int unsigned pos;
    r   = '0;
    cap = effective_cap(mirror_cap);
    ev  = '{frame: rq.frame_number, x: rq.cell_x, y: rq.cell_y, z: rq.cell_z,
            level: rq.cell_level, layer: rq.world_layer, kind: rq.event_kind};
    case (rq.operation)
      OP_RECORD: begin
        n_records++;
        if (mirror_fill < cap) begin
          ring_mirror[mirror_fill] = ev;
          mirror_fill++;
        end else begin
          // full: overwrite the oldest entry and move the head on
          pos                = mirror_oldest % cap;
          ring_mirror[pos]   = ev;
          mirror_oldest      = (pos + 1) % cap;
          mirror_wrapped     = 1'b1;
          mirror_dropped     = mirror_dropped + 64'd1;
          n_overwrites++;
        end
      end
      OP_READ: begin
        n_reads++;
        if (rq.read_index < mirror_fill) begin
          pos           = (mirror_oldest + rq.read_index) % mirror_fill;
          ev            = ring_mirror[pos];
          r.entry_valid = 1'b1;
          r.out_frame   = ev.frame;
          r.out_x       = ev.x;
          r.out_y       = ev.y;
          r.out_z       = ev.z;
          r.out_level   = ev.level;
          r.out_layer   = ev.layer;
          r.out_kind    = ev.kind;
          n_hits++;
        end
      end
      OP_CLEAR: begin
        n_clears++;
        empty_mirror();
      end
      default: n_spare++;
    endcase
    r.stored_count  = mirror_fill[CountW-1:0];
    r.dropped_count = mirror_dropped;
    r.log_wrapped   = mirror_wrapped;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // result checking and command tracking, all on the rising edge
  // ---------------------------------------------------------------------

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    erl_res_t want;
    erl_res_t pred;
    if (res_valid_o === 1'b1) begin
      n_results++;
      if (pending_res_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got %h", $time, res_o);
        error_count++;
      end else begin
        want = pending_res_q.pop_front();
        check_field("entry_valid", want.entry_valid, res_o.entry_valid);
        check_field("out_frame", want.out_frame, res_o.out_frame);
        check_field("out_x", want.out_x, res_o.out_x);
        check_field("out_y", want.out_y, res_o.out_y);
        check_field("out_z", want.out_z, res_o.out_z);
        check_field("out_level", want.out_level, res_o.out_level);
        check_field("out_layer", want.out_layer, res_o.out_layer);
        check_field("out_kind", want.out_kind, res_o.out_kind);
        check_field("stored_count", want.stored_count, res_o.stored_count);
        check_field("dropped_count", want.dropped_count, res_o.dropped_count);
        check_field("log_wrapped", want.log_wrapped, res_o.log_wrapped);
      end
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      mirror_set_capacity(cfg_data_i);
    end
    // command transfer: the mirror always steps, the typed value wins if given
    if (rst_ni && start && !busy) begin
      pred = ring_log_step(req_i);
      pending_res_q = {pending_res_q, (drv_typed ? drv_typed_res : pred)};
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------

  function automatic erl_req_t make_req(logic [1:0] op, logic [63:0] f, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z, logic [31:0] lv,
                                        logic [7:0] ly, logic [1:0] k, logic [7:0] idx);
    erl_req_t rq;
    rq = '{operation: op, frame_number: f, cell_x: x, cell_y: y, cell_z: z,
           cell_level: lv, world_layer: ly, event_kind: k, read_index: idx};
    return rq;
  endfunction

  // result of anything that returns no entry
  function automatic erl_res_t bare_res(int unsigned cnt, int unsigned drop, int wr);
    erl_res_t r;
    r               = '0;
    r.stored_count  = CountW'(cnt);
    r.dropped_count = 64'(drop);
    r.log_wrapped   = (wr != 0);
    return r;
  endfunction

  // mostly random words, now and then one of the corners
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic erl_req_t rand_cmd(logic [1:0] op, logic [7:0] idx);
    return make_req(op, {$urandom, $urandom}, pick_word(), pick_word(), pick_word(),
                    pick_word(), 8'($urandom), 2'($urandom), idx);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_cmd(erl_req_t rq, int typed, erl_res_t res);
    stim_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, req: rq, typed: (typed != 0), res: res};
    directed_q = {directed_q, row};
  endtask

  task automatic add_cap(logic [CapW-1:0] v);
    stim_row_t row;
    row = '{is_cfg: 1'b1, cap: v, req: '0, typed: 1'b0, res: '0};
    directed_q = {directed_q, row};
  endtask

  // offer one command, idling first for gap cycles, until it is taken
  task automatic send_cmd(erl_req_t rq, bit typed, erl_res_t res, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    req_i         <= rq;
    drv_typed     <= typed;
    drv_typed_res <= res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off until every expected result has arrived, then let the pipe settle
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_res_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (ResLatency + 1) @(negedge clk_i);
    if (pending_res_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, got none", $time,
               pending_res_q.size());
      error_count++;
      pending_res_q.delete();
    end
  endtask

  // capacity write; only ever called after drain, so the log is idle
  task automatic write_cap(logic [CapW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    logic [CapW-1:0] phase_caps [$];
    logic [CapW-1:0] cap_v;
    logic [7:0]      idx;
    logic [1:0]      op;
    erl_req_t        rq;
    int unsigned     eff;
    int              n_items;
    int              rec_pct;
    int              r;
    bit              no_gaps;

    rst_ni        <= 1'b0;
    start         <= 1'b0;
    req_i         <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    drv_typed     <= 1'b0;
    drv_typed_res <= '0;
    error_count   = 0;
    n_records = 0; n_reads = 0; n_hits = 0; n_clears = 0; n_spare = 0;
    n_overwrites = 0; n_cap_writes = 0; n_results = 0;
    mirror_cap    = CapReset;
    empty_mirror();
    foreach (ring_mirror[i]) ring_mirror[i] = '0;

    // directed part, log at its reset capacity of 256
    // empty log: read, spare code and clear all give a bare result
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd0), 1, bare_res(0, 0, 0));
    add_cmd(make_req(OpSpare, '0, '0, '0, '0, '0, '0, '0, 8'd0), 1, bare_res(0, 0, 0));
    add_cmd(make_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, 8'd0), 1, bare_res(0, 0, 0));
    // all fields at their top, then at their bottom
    add_cmd(make_req(OP_RECORD, '1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1,
                     8'hff, 2'd3, 8'hff), 1, bare_res(1, 0, 0));
    add_cmd(make_req(OP_RECORD, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0,
                     8'h00, 2'd0, 8'h00), 1, bare_res(2, 0, 0));
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd0), 0, '0);
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd1), 0, '0);
    // reads past the fill count
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd2), 1, bare_res(2, 0, 0));
    add_cmd(make_req(OP_READ, '1, '1, '1, '1, '1, '1, '1, 8'd255), 1, bare_res(2, 0, 0));
    // spare code leaves a filled log alone
    add_cmd(make_req(OpSpare, '1, '1, '1, '1, '1, '1, '1, 8'd0), 1, bare_res(2, 0, 0));
    add_cmd(make_req(OP_RECORD, 64'h1234_5678_9abc_def0, 32'hffff_ffff, 32'd1, 32'd0,
                     32'd7, 8'h5a, 2'd1, 8'd0), 0, '0);
    add_cmd(make_req(OP_RECORD, 64'hfedc_ba98_7654_3210, 32'd0, 32'hffff_fffe, 32'd5,
                     32'd9, 8'ha5, 2'd2, 8'd0), 0, '0);
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd3), 0, '0);
    add_cmd(make_req(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, 8'd0), 1, bare_res(0, 0, 0));
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd0), 1, bare_res(0, 0, 0));
    // capacity 0 behaves as 1: the second record already overwrites
    add_cap(9'd0);
    add_cmd(rand_cmd(OP_RECORD, 8'd0), 1, bare_res(1, 0, 0));
    add_cmd(rand_cmd(OP_RECORD, 8'd0), 1, bare_res(1, 1, 1));
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd0), 0, '0);
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd1), 1, bare_res(1, 1, 1));
    // top code behaves as 256, and the write empties the log
    add_cap(9'd511);
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd0), 1, bare_res(0, 0, 0));
    add_cmd(rand_cmd(OP_RECORD, 8'd0), 1, bare_res(1, 0, 0));
    // capacity 2: third record overwrites the oldest
    add_cap(9'd2);
    repeat (3) add_cmd(rand_cmd(OP_RECORD, 8'd0), 0, '0);
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd0), 0, '0);
    add_cmd(make_req(OP_READ, '0, '0, '0, '0, '0, '0, '0, 8'd1), 0, '0);

    // reset held, then lifted on a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_q[i]) begin
      if (directed_q[i].is_cfg) begin
        drain();
        write_cap(directed_q[i].cap);
      end else begin
        send_cmd(directed_q[i].req, directed_q[i].typed, directed_q[i].res, pick_gap());
      end
    end

    // random part: one phase per capacity setting, extremes among them
    phase_caps = {9'd1, 9'd3, 9'd2, 9'd5, 9'd256, 9'd16, 9'd0, 9'd8, 9'd300,
                  9'd4, 9'd64, 9'd7, 9'($urandom_range(1, 40))};
    foreach (phase_caps[p]) begin
      cap_v = phase_caps[p];
      eff   = effective_cap(cap_v);
      // enough records in every phase, on average, to fill and wrap the ring
      if (eff <= 16) begin
        n_items = 40;
        rec_pct = 55;
      end else if (eff <= 64) begin
        n_items = 100;
        rec_pct = 70;
      end else begin
        n_items = 400;
        rec_pct = 80;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      drain();
      write_cap(cap_v);
      for (int i = 0; i < n_items; i++) begin
        // above a capacity of 64, one pause mid-phase until the pipe is empty
        if (eff > 64 && i == n_items / 2) drain();
        r = $urandom_range(0, 99);
        if (r < rec_pct) op = OP_RECORD;
        else if (r < 96) op = OP_READ;
        else if (r < 98) op = OP_CLEAR;
        else op = OpSpare;
        // reads mostly land inside the log, the rest anywhere
        if (mirror_fill > 0 && $urandom_range(0, 4) != 0)
          idx = 8'($urandom_range(0, mirror_fill - 1));
        else
          idx = 8'($urandom_range(0, 255));
        rq = rand_cmd(op, idx);
        send_cmd(rq, 1'b0, '0, no_gaps ? 0 : pick_gap());
      end
    end

    drain();

    $display("covered %0d records (%0d overwrites), %0d reads (%0d hits), %0d clears,",
             n_records, n_overwrites, n_reads, n_hits, n_clears);
    $display("%0d spare codes and %0d capacity writes; %0d results checked",
             n_spare, n_cap_writes, n_results);
    if (error_count == 0) begin
      $display("[overwriting_event_ring_log_top] OK");
    end else begin
      $display("[overwriting_event_ring_log_top] ERROR");
    end
    $finish;
  end

endmodule
